[design/sbgr_pkg.sv]
// ----------------------------------------------------------------------------
// sbgr_pkg
// Shared constants, register codes and types of the smoothed bar graph renderer.
// ----------------------------------------------------------------------------
package sbgr_pkg;

   localparam int BAR_COLUMNS     = 25;
   localparam int ROWS_PER_COLUMN = 7;
   localparam int FULL_ROWS       = BAR_COLUMNS * ROWS_PER_COLUMN;
   localparam int LEVEL_MAX       = FULL_ROWS * 256;

   // field widths
   localparam int USAGE_W = 10;
   localparam int COL_W   = 5;
   localparam int PAT_W   = 7;
   localparam int CSR_A_W = 3;

   localparam int USAGE_MAX = 1000;

   // internal widths
   localparam int LEVEL_W = $clog2(LEVEL_MAX + 1);
   localparam int ROWS_W  = $clog2(FULL_ROWS + 1);
   localparam int FILL_W  = $clog2(BAR_COLUMNS + 1);
   localparam int FRAC_W  = 3;
   localparam int X_W     = $clog2(USAGE_MAX * FULL_ROWS + 1);

   // target = (32*x + 62) / 125 with x = usage * FULL_ROWS
   localparam int TGT_SCALE_SHIFT = 5;
   localparam int TGT_BIAS        = 62;
   localparam int Z_W             = X_W + TGT_SCALE_SHIFT + 1;
   localparam int TGT_RECIP_W     = 25;
   localparam logic [TGT_RECIP_W-1:0] TGT_RECIP = 25'd17179870;
   localparam int TGT_SHIFT       = 31;
   localparam int TGT_PROD_W      = Z_W + TGT_RECIP_W;

   // smoothing
   localparam int SMOOTH_GAIN  = 77;
   localparam int SMOOTH_SHIFT = 8;
   localparam int SNAP_RANGE   = 256;
   localparam int ROUND_HALF   = 128;

   // rows / ROWS_PER_COLUMN by reciprocal
   localparam int FILL_SHIFT = 16;
   localparam int FILL_RECIP_W = 17;
   localparam logic [FILL_RECIP_W-1:0] FILL_RECIP =
      FILL_RECIP_W'(((1 << FILL_SHIFT) + ROWS_PER_COLUMN - 1) / ROWS_PER_COLUMN);
   localparam int FILL_PROD_W = ROWS_W + FILL_RECIP_W;

   localparam logic [PAT_W-1:0] FULL_PAT =
      PAT_W'(((1 << ROWS_PER_COLUMN) - 1) & 'h7f);
   localparam logic [PAT_W-1:0] ALL_ROWS_PAT = PAT_W'('h7f);

   // configuration register codes
   localparam int NUM_REGS = 6;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_ONE_ROW    = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_TWO_ROWS   = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_THREE_ROWS = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_FOUR_ROWS  = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_FIVE_ROWS  = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_PARTIAL_SIX_ROWS   = 3'd5;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic              empty;
      logic [ROWS_W-1:0] rows;
   } sbgr_desc_type;

endpackage

[design/smoothed_bar_graph_renderer.sv]
// ----------------------------------------------------------------------------
// smoothed_bar_graph_renderer
// Per-frame utilisation sample in, 25 seven-row bar column words out per connected frame.
// A sample passes the level pipeline, the descriptor queue and the output register
// before its first column word; words leave one per cycle while rsp_tready is high,
// and samples keep flowing while a frame is being emitted until the queue is full.
// Reset (synchronous): level 0, first-frame flag set, partial table to its
// defaults, queue and output empty.
// ----------------------------------------------------------------------------
module smoothed_bar_graph_renderer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // usage_tenths[9:0], zero pad
   input  logic                          req_tuser,   // link_up
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // column_index[4:0], column_pattern[11:5]
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [sbgr_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [sbgr_pkg::PAT_W-1:0]    csr_wdata
);

   logic                          q_push;
   logic                          q_full;
   logic                          q_pop;
   logic                          q_avail;
   sbgr_pkg::sbgr_desc_type       q_push_desc;
   sbgr_pkg::sbgr_desc_type       q_pop_desc;
   logic [sbgr_pkg::COL_W-1:0]    col_index;
   logic [sbgr_pkg::PAT_W-1:0]    col_pattern;

   sbgr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .link_up      (req_tuser),
      .usage_tenths (req_tdata[sbgr_pkg::USAGE_W-1:0]),
      .push         (q_push),
      .push_desc    (q_push_desc),
      .queue_full   (q_full)
   );

   sbgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .avail     (q_avail),
      .pop_desc  (q_pop_desc)
   );

   sbgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .avail       (q_avail),
      .pop_desc    (q_pop_desc),
      .pop         (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_index   (col_index),
      .out_pattern (col_pattern),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, col_pattern, col_index};

   // the last word of a frame is always the rightmost column
   a_last_is_rightmost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> col_index == sbgr_pkg::COL_W'(sbgr_pkg::BAR_COLUMNS - 1))
      else $error("last word not on rightmost column");

   // no push into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue overrun");

   // input only backs off while the queue is full
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_full)
      else $error("input stalled with room in queue");

   // columns of a frame come out in order with no gaps
   a_columns_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && col_index == $past(col_index) + 1'b1)
      else $error("column sequence broken");

endmodule

[design/sbgr_front.sv]
// ----------------------------------------------------------------------------
// sbgr_front
// Takes samples, tracks the first-frame flag, computes the target and the
// smoothed level, and hands one frame descriptor per connected frame on.
// ----------------------------------------------------------------------------
module sbgr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          link_up,
   input  logic [sbgr_pkg::USAGE_W-1:0]  usage_tenths,
   output logic                          push,
   output sbgr_pkg::sbgr_desc_type       push_desc,
   input  logic                          queue_full
);

   logic                          advance;
   logic                          accept;
   logic                          first_ff, first_in;

   logic                          v1_ff, v1_in;
   logic                          empty1_ff;
   logic [sbgr_pkg::X_W-1:0]      x1_ff, x1_in;

   logic                          v2_ff;
   logic                          empty2_ff;
   logic [sbgr_pkg::LEVEL_W-1:0]  target2_ff, target2_in;

   logic                          v3_ff;
   logic                          empty3_ff;

   logic [sbgr_pkg::LEVEL_W-1:0]  level_ff, level_in;

   logic [sbgr_pkg::USAGE_W-1:0]      usage_sat;
   logic [sbgr_pkg::Z_W-1:0]          z;
   logic [sbgr_pkg::TGT_PROD_W-1:0]   tgt_prod;

   logic signed [sbgr_pkg::LEVEL_W:0]   diff;
   logic signed [sbgr_pkg::LEVEL_W+8:0] step_prod;
   logic signed [sbgr_pkg::LEVEL_W+8:0] step_full;
   logic signed [sbgr_pkg::LEVEL_W+1:0] lvl_sum;
   logic signed [sbgr_pkg::LEVEL_W+1:0] lvl_next;
   logic [sbgr_pkg::LEVEL_W:0]          rounded;

   assign advance  = !v3_ff || !queue_full;
   assign in_ready = advance;
   assign accept   = in_valid && advance;
   assign push     = v3_ff && !queue_full;

   // stage one: saturate and scale
   always_comb begin
      usage_sat = (usage_tenths > sbgr_pkg::USAGE_W'(sbgr_pkg::USAGE_MAX)) ?
                  sbgr_pkg::USAGE_W'(sbgr_pkg::USAGE_MAX) : usage_tenths;
      x1_in     = sbgr_pkg::X_W'(usage_sat * sbgr_pkg::FULL_ROWS);
      v1_in     = accept && link_up;
      first_in  = first_ff;
      if (accept) begin
         first_in = !link_up;
      end
   end

   // stage two: divide by 125 through the reciprocal
   always_comb begin
      z          = (sbgr_pkg::Z_W'(x1_ff) << sbgr_pkg::TGT_SCALE_SHIFT) +
                   sbgr_pkg::Z_W'(sbgr_pkg::TGT_BIAS);
      tgt_prod   = sbgr_pkg::TGT_PROD_W'(z) * sbgr_pkg::TGT_PROD_W'(sbgr_pkg::TGT_RECIP);
      target2_in = tgt_prod[sbgr_pkg::TGT_SHIFT +: sbgr_pkg::LEVEL_W];
   end

   // stage three: smoothing step, snap and clamp
   always_comb begin
      diff      = $signed({1'b0, target2_ff}) - $signed({1'b0, level_ff});
      step_prod = (sbgr_pkg::LEVEL_W+9)'(diff) * (sbgr_pkg::LEVEL_W+9)'(sbgr_pkg::SMOOTH_GAIN);
      step_full = step_prod >>> sbgr_pkg::SMOOTH_SHIFT;
      lvl_sum   = $signed({2'b00, level_ff}) + $signed(step_full[sbgr_pkg::LEVEL_W+1:0]);
      if (diff > $signed((sbgr_pkg::LEVEL_W+1)'(sbgr_pkg::SNAP_RANGE)) ||
          diff < -$signed((sbgr_pkg::LEVEL_W+1)'(sbgr_pkg::SNAP_RANGE))) begin
         lvl_next = lvl_sum;
      end else begin
         lvl_next = $signed({2'b00, target2_ff});
      end
      if (lvl_next < 0) begin
         lvl_next = '0;
      end else if (lvl_next > $signed((sbgr_pkg::LEVEL_W+2)'(sbgr_pkg::LEVEL_MAX))) begin
         lvl_next = $signed((sbgr_pkg::LEVEL_W+2)'(sbgr_pkg::LEVEL_MAX));
      end
      level_in = level_ff;
      if (advance && v2_ff && !empty2_ff) begin
         level_in = sbgr_pkg::LEVEL_W'(lvl_next);
      end
   end

   // stage four: round half up to whole rows
   always_comb begin
      rounded         = {1'b0, level_ff} + (sbgr_pkg::LEVEL_W+1)'(sbgr_pkg::ROUND_HALF);
      push_desc.empty = empty3_ff;
      push_desc.rows  = rounded[sbgr_pkg::SMOOTH_SHIFT +: sbgr_pkg::ROWS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         level_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         first_ff <= first_in;
         level_ff <= level_in;
         if (advance) begin
            v1_ff <= v1_in;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         empty1_ff  <= first_ff;
         x1_ff      <= x1_in;
         empty2_ff  <= empty1_ff;
         target2_ff <= target2_in;
         empty3_ff  <= empty2_ff;
      end
   end

endmodule

[design/sbgr_queue.sv]
// ----------------------------------------------------------------------------
// sbgr_queue
// Two-entry descriptor queue between the level pipeline and the column emitter.
// ----------------------------------------------------------------------------
module sbgr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sbgr_pkg::sbgr_desc_type  push_desc,
   output logic                     full,
   input  logic                     pop,
   output logic                     avail,
   output sbgr_pkg::sbgr_desc_type  pop_desc
);

   localparam int PTR_W = $clog2(sbgr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sbgr_pkg::QUEUE_DEPTH + 1);

   sbgr_pkg::sbgr_desc_type entry_ff [sbgr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(sbgr_pkg::QUEUE_DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[design/sbgr_back.sv]
// ----------------------------------------------------------------------------
// sbgr_back
// Column emitter: holds the partial-column table and walks one frame
// descriptor out as one column word per cycle unless out_ready stalls the output.
// ----------------------------------------------------------------------------
module sbgr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sbgr_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [sbgr_pkg::PAT_W-1:0]    csr_wdata,
   input  logic                          avail,
   input  sbgr_pkg::sbgr_desc_type       pop_desc,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [sbgr_pkg::COL_W-1:0]    out_index,
   output logic [sbgr_pkg::PAT_W-1:0]    out_pattern,
   output logic                          out_last
);

   logic [sbgr_pkg::PAT_W-1:0]   part_ff [sbgr_pkg::NUM_REGS];

   logic                         busy_ff, busy_in;
   logic                         empty_ff;
   logic [sbgr_pkg::ROWS_W-1:0]  rows_ff;
   logic [sbgr_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [sbgr_pkg::COL_W-1:0]   col_ff, col_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sbgr_pkg::COL_W-1:0]   rsp_index_ff;
   logic [sbgr_pkg::PAT_W-1:0]   rsp_pattern_ff;
   logic                         rsp_last_ff;

   logic                             load;
   logic                             last_col;
   logic [sbgr_pkg::FILL_PROD_W-1:0] fill_prod;
   logic [sbgr_pkg::ROWS_W-1:0]      frac_full;
   logic [sbgr_pkg::FRAC_W-1:0]      frac;
   logic [sbgr_pkg::FRAC_W-1:0]      frac_idx;
   logic [sbgr_pkg::COL_W-1:0]       from_right;
   logic [sbgr_pkg::PAT_W-1:0]       partial_pat;
   logic [sbgr_pkg::PAT_W-1:0]       pattern;

   assign load     = !rsp_valid_ff || out_ready;
   assign last_col = (col_ff == sbgr_pkg::COL_W'(sbgr_pkg::BAR_COLUMNS - 1));
   assign pop      = avail && (!busy_ff || (load && last_col));

   assign out_valid   = rsp_valid_ff;
   assign out_index   = rsp_index_ff;
   assign out_pattern = rsp_pattern_ff;
   assign out_last    = rsp_last_ff;

   always_comb begin
      fill_prod = sbgr_pkg::FILL_PROD_W'(pop_desc.rows) *
                  sbgr_pkg::FILL_PROD_W'(sbgr_pkg::FILL_RECIP);
      fill_in   = fill_prod[sbgr_pkg::FILL_SHIFT +: sbgr_pkg::FILL_W];
   end

   // pattern of the column currently at the head
   always_comb begin
      frac_full  = rows_ff - sbgr_pkg::ROWS_W'(fill_ff * sbgr_pkg::ROWS_PER_COLUMN);
      frac       = frac_full[sbgr_pkg::FRAC_W-1:0];
      frac_idx   = frac - 1'b1;
      from_right = sbgr_pkg::COL_W'(sbgr_pkg::BAR_COLUMNS - 1) - col_ff;
      if (frac == '0) begin
         partial_pat = '0;
      end else if (frac <= sbgr_pkg::FRAC_W'(sbgr_pkg::NUM_REGS)) begin
         partial_pat = part_ff[frac_idx];
      end else begin
         partial_pat = sbgr_pkg::ALL_ROWS_PAT;
      end
      if (empty_ff) begin
         pattern = '0;
      end else if (sbgr_pkg::FILL_W'(from_right) < fill_ff) begin
         pattern = sbgr_pkg::FULL_PAT;
      end else if (sbgr_pkg::FILL_W'(from_right) == fill_ff) begin
         pattern = partial_pat;
      end else begin
         pattern = '0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      if (pop) begin
         busy_in = 1'b1;
         col_in  = '0;
      end else if (load && busy_ff) begin
         if (last_col) begin
            busy_in = 1'b0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      rsp_valid_in = load ? busy_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         empty_ff <= pop_desc.empty;
         rows_ff  <= pop_desc.rows;
         fill_ff  <= fill_in;
      end
      if (load && busy_ff) begin
         rsp_index_ff   <= col_ff;
         rsp_pattern_ff <= pattern;
         rsp_last_ff    <= last_col;
      end
   end

   // partial-column table
   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff[0] <= 7'd1;
         part_ff[1] <= 7'd3;
         part_ff[2] <= 7'd7;
         part_ff[3] <= 7'd15;
         part_ff[4] <= 7'd31;
         part_ff[5] <= 7'd63;
      end else if (csr_we) begin
         case (csr_addr)
            sbgr_pkg::REG_PARTIAL_ONE_ROW:    part_ff[0] <= csr_wdata;
            sbgr_pkg::REG_PARTIAL_TWO_ROWS:   part_ff[1] <= csr_wdata;
            sbgr_pkg::REG_PARTIAL_THREE_ROWS: part_ff[2] <= csr_wdata;
            sbgr_pkg::REG_PARTIAL_FOUR_ROWS:  part_ff[3] <= csr_wdata;
            sbgr_pkg::REG_PARTIAL_FIVE_ROWS:  part_ff[4] <= csr_wdata;
            sbgr_pkg::REG_PARTIAL_SIX_ROWS:   part_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

[tb/smoothed_bar_graph_renderer_tb.sv]
// ----------------------------------------------------------------------------
// smoothed_bar_graph_renderer_tb
// Self-checking bench for the bar graph renderer. Frame samples are pushed
// through the request stream, and a frame model predicts the 25 column words
// of each connected frame, which are checked in order against the response
// stream. The partial column table is reprogrammed between phases of random
// traffic, with back-pressure on the response stream in all phases but the last.
// ----------------------------------------------------------------------------
module smoothed_bar_graph_renderer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;
   localparam logic [sbgr_pkg::CSR_A_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [sbgr_pkg::CSR_A_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic                         link_up;
      logic [sbgr_pkg::USAGE_W-1:0] usage;
   } frame_sample_type;

   typedef struct packed {
      logic [sbgr_pkg::COL_W-1:0] index;
      logic [sbgr_pkg::PAT_W-1:0] pattern;
      logic                       last;
   } column_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [15:0]                   req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [15:0]                   rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [sbgr_pkg::CSR_A_W-1:0]  csr_addr = '0;
   logic [sbgr_pkg::PAT_W-1:0]    csr_wdata = '0;

   // frame model state
   logic [sbgr_pkg::LEVEL_W-1:0]  bar_level = '0;
   logic                          first_frame = 1'b1;
   logic [sbgr_pkg::PAT_W-1:0]    partial_tbl [sbgr_pkg::NUM_REGS] =
      '{7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63};

   frame_sample_type    pending_frames [$];
   column_word_type     column_words_due [$];
   logic                req_fire = 1'b0;
   int                  send_idle_pct = 13;
   int                  rsp_idle_pct = 46;
   int                  mismatches = 0;
   int                  cycles = 0;

   smoothed_bar_graph_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // advance the smoothed level and queue the column words of one connected frame
   function automatic void render_frame(frame_sample_type s);
      int                         usage;
      int                         target;
      int                         diff;
      int                         lvl;
      int                         rows;
      int                         fill;
      int                         frac;
      int                         from_right;
      logic [sbgr_pkg::PAT_W-1:0] pat;
      logic                       empty;
      column_word_type            w;

      if (!s.link_up) begin
         first_frame = 1'b1;
         return;
      end
      empty = first_frame;
      fill = 0;
      frac = 0;
      if (first_frame) begin
         first_frame = 1'b0;
      end else begin
         usage = (s.usage > sbgr_pkg::USAGE_MAX) ? sbgr_pkg::USAGE_MAX : int'(s.usage);
         target = (usage * sbgr_pkg::FULL_ROWS * 256 + 500) / 1000;
         lvl = int'(bar_level);
         diff = target - lvl;
         if (diff > sbgr_pkg::SNAP_RANGE || diff < -sbgr_pkg::SNAP_RANGE) begin
            // arithmetic shift floors towards minus infinity
            lvl = lvl + ((diff * sbgr_pkg::SMOOTH_GAIN) >>> sbgr_pkg::SMOOTH_SHIFT);
         end else begin
            lvl = target;
         end
         if (lvl < 0) lvl = 0;
         if (lvl > sbgr_pkg::LEVEL_MAX) lvl = sbgr_pkg::LEVEL_MAX;
         bar_level = sbgr_pkg::LEVEL_W'(lvl);
         rows = (lvl + sbgr_pkg::ROUND_HALF) >> 8;
         fill = rows / sbgr_pkg::ROWS_PER_COLUMN;
         frac = rows % sbgr_pkg::ROWS_PER_COLUMN;
      end
      for (int c = 0; c < sbgr_pkg::BAR_COLUMNS; c++) begin
         from_right = sbgr_pkg::BAR_COLUMNS - 1 - c;
         pat = '0;
         if (!empty) begin
            if (from_right < fill) begin
               pat = sbgr_pkg::FULL_PAT;
            end else if (from_right == fill) begin
               if (frac == 0) pat = '0;
               else if (frac <= sbgr_pkg::NUM_REGS) pat = partial_tbl[frac-1];
               else pat = sbgr_pkg::ALL_ROWS_PAT;
            end
         end
         w.index = sbgr_pkg::COL_W'(c);
         w.pattern = pat;
         w.last = (c == sbgr_pkg::BAR_COLUMNS - 1);
         column_words_due.push_back(w);
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      frame_sample_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_frames.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            s = pending_frames.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= 16'(s.usage);
            req_tuser  <= s.link_up;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // accept side: predict on request words, check response words
   always @(posedge clock) begin : monitor
      column_word_type  got;
      column_word_type  want;
      frame_sample_type s;
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         s.link_up = req_tuser;
         s.usage = req_tdata[sbgr_pkg::USAGE_W-1:0];
         render_frame(s);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.index   = rsp_tdata[sbgr_pkg::COL_W-1:0];
         got.pattern = rsp_tdata[sbgr_pkg::COL_W+sbgr_pkg::PAT_W-1:sbgr_pkg::COL_W];
         got.last    = rsp_tlast;
         if (column_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected word: index %0d pattern %h last %b",
                        got.index, got.pattern, got.last);
         end else begin
            want = column_words_due.pop_front();
            if (got.index !== want.index || got.pattern !== want.pattern ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"word mismatch: exp index %0d pattern %h last %b, ",
                            "got index %0d pattern %h last %b"},
                           want.index, want.pattern, want.last,
                           got.index, got.pattern, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_frame(input logic link_up, input int usage);
      frame_sample_type s;
      s.link_up = link_up;
      s.usage = sbgr_pkg::USAGE_W'(usage);
      pending_frames.push_back(s);
   endtask

   // runs of similar samples let the level settle; some noise and dropouts
   task automatic queue_random_frames(input int count);
      int n;
      int run_len;
      int base;
      n = 0;
      while (n < count) begin
         run_len = $urandom_range(1, 10);
         case ($urandom_range(0, 5))
            0:       base = 0;
            1:       base = $urandom_range(1001, 1023);
            2:       base = sbgr_pkg::USAGE_MAX;
            default: base = $urandom_range(0, 1023);
         endcase
         for (int i = 0; i < run_len && n < count; i++) begin
            if ($urandom_range(0, 99) < 8) begin
               push_frame(1'b0, $urandom_range(0, 1023));
            end else begin
               if ($urandom_range(0, 99) < 30) push_frame(1'b1, $urandom_range(0, 1023));
               else push_frame(1'b1, base);
               n++;
            end
         end
      end
   endtask

   // let everything queued reach the DUT, then cover words still in flight
   task automatic wait_until_idle();
      while (pending_frames.size() != 0 || req_tvalid) @(posedge clock);
      while (column_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sbgr_pkg::CSR_A_W-1:0] addr,
                            input logic [sbgr_pkg::PAT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      if (addr < sbgr_pkg::NUM_REGS) partial_tbl[addr] = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first frame is empty, then climb from saturated samples to full scale and fall back to zero
      push_frame(1'b1, 500);
      push_frame(1'b1, 0);
      for (int i = 0; i < 12; i++) push_frame(1'b1, 1023);
      push_frame(1'b1, sbgr_pkg::USAGE_MAX);
      push_frame(1'b1, sbgr_pkg::USAGE_MAX);
      push_frame(1'b1, 0);
      push_frame(1'b1, 0);
      push_frame(1'b1, 0);
      // dropout, then the reconnect frame comes out empty
      push_frame(1'b0, 1023);
      push_frame(1'b1, 700);
      push_frame(1'b1, 1);
      push_frame(1'b1, 999);
      push_frame(1'b1, 682);
      wait_until_idle();

      for (int i = 0; i < sbgr_pkg::NUM_REGS; i++)
         write_reg(sbgr_pkg::REG_PARTIAL_ONE_ROW + sbgr_pkg::CSR_A_W'(i),
                   sbgr_pkg::PAT_W'($urandom_range(0, 127)));
      write_reg(REG_UNMAPPED_LO, sbgr_pkg::PAT_W'($urandom_range(0, 127)));
      queue_random_frames(35);
      wait_until_idle();

      send_idle_pct = 46;
      rsp_idle_pct = 13;
      for (int i = 0; i < sbgr_pkg::NUM_REGS; i++)
         write_reg(sbgr_pkg::REG_PARTIAL_ONE_ROW + sbgr_pkg::CSR_A_W'(i), 7'h7f);
      write_reg(REG_UNMAPPED_HI, 7'h00);
      queue_random_frames(35);
      wait_until_idle();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int i = 0; i < sbgr_pkg::NUM_REGS; i++)
         write_reg(sbgr_pkg::REG_PARTIAL_ONE_ROW + sbgr_pkg::CSR_A_W'(i), 7'h00);
      write_reg(REG_UNMAPPED_LO, 7'h7f);
      queue_random_frames(30);
      wait_until_idle();

      if (mismatches == 0 && column_words_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/sbgr_pkg.sv
design/sbgr_front.sv
design/sbgr_queue.sv
design/sbgr_back.sv
design/smoothed_bar_graph_renderer.sv
tb/smoothed_bar_graph_renderer_tb.sv
